@@ sv/abn_pkg.sv @@
// Package: widths, state encoding and control structs for the abundant number checker.
`default_nettype none

package abn_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int CAND_WIDTH  = VALUE_WIDTH - 1;
    localparam int SUM_WIDTH   = VALUE_WIDTH + 1;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int TDATA_IN_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
    } rem_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

`default_nettype wire

@@ sv/abn_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module abn_rem (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire abn_pkg::rem_ctrl_t            ctrl,
    input  wire [abn_pkg::VALUE_WIDTH-1:0]     dividend,
    input  wire [abn_pkg::CAND_WIDTH-1:0]      divisor,
    output abn_pkg::rem_stat_t                 stat
);

    logic                              busy_reg,  busy_next;
    logic                              done_reg,  done_next;
    logic [abn_pkg::CNT_WIDTH-1:0]     cnt_reg,   cnt_next;
    logic [abn_pkg::VALUE_WIDTH-1:0]   dvd_reg,   dvd_next;
    logic [abn_pkg::CAND_WIDTH-1:0]    rem_reg,   rem_next;
    logic [abn_pkg::VALUE_WIDTH-1:0]   trial;
    logic [abn_pkg::VALUE_WIDTH-1:0]   diff;

    // Shift the next dividend bit into the partial remainder
    assign trial = {rem_reg, dvd_reg[abn_pkg::VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = abn_pkg::CNT_WIDTH'(abn_pkg::VALUE_WIDTH - 1);
            dvd_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[abn_pkg::VALUE_WIDTH-2:0], 1'b0};
            // Restore when the trial subtract would go negative
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[abn_pkg::CAND_WIDTH-1:0];
            end else begin
                rem_next = trial[abn_pkg::CAND_WIDTH-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

`default_nettype wire

@@ sv/abundant_number_check.sv @@
// Top level: abundance test over all candidate divisors with a serial remainder unit.
// Usage:
//   Input channel s_*: one signed value per transfer in s_tdata[15:0].
//   Result channel m_*: one transfer per input, abundant flag in m_tdata[0].
//   s_tready is high only while the block is idle; one item is worked on at a time.
//   A zero or negative value is answered 0 without division, as is the value one.
//   For a positive value n, candidates 1 .. floor(n/2) are tried in turn; each
//   candidate takes a load step, a bit-serial remainder over all 16 dividend bits
//   and an accumulate step. The search stops early once the divisor sum exceeds n.
//   The result sits in an output register; the block may take the next item
//   while it waits. If the receiver stalls with a new result pending, the
//   block holds that result in its done state until the register frees.
//   Reset (aresetn low, synchronous) returns to idle and empties the output.
`default_nettype none

module abundant_number_check (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [abn_pkg::TDATA_IN_W-1:0]      s_tdata,   // [15:0] number
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [abn_pkg::TDATA_OUT_W-1:0]    m_tdata    // [0] abundant, [7:1] zero
);

    abn_pkg::state_t                   state_reg, state_next;
    logic [abn_pkg::VALUE_WIDTH-1:0]   n_reg,     n_next;
    logic [abn_pkg::CAND_WIDTH-1:0]    half_reg,  half_next;
    logic [abn_pkg::CAND_WIDTH-1:0]    cand_reg,  cand_next;
    logic [abn_pkg::SUM_WIDTH-1:0]     sum_reg,   sum_next;
    logic                              flag_reg,  flag_next;
    logic                              mvalid_reg, mvalid_next;
    logic                              mflag_reg,  mflag_next;

    logic [abn_pkg::VALUE_WIDTH-1:0]   s_number;
    logic                              s_xfer;
    logic                              s_trivial;
    logic [abn_pkg::SUM_WIDTH-1:0]     sum_add;
    logic                              sum_over;
    logic                              last_cand;
    logic                              out_free;
    abn_pkg::rem_ctrl_t                rem_ctrl;
    abn_pkg::rem_stat_t                rem_stat;

    assign s_number  = s_tdata[abn_pkg::VALUE_WIDTH-1:0];
    assign s_xfer    = s_tvalid && s_tready;
    // Non-positive values and the value one need no division
    assign s_trivial = s_number[abn_pkg::VALUE_WIDTH-1]
                       || (s_number[abn_pkg::VALUE_WIDTH-1:1] == '0);
    assign sum_add   = rem_stat.zero ? sum_reg + abn_pkg::SUM_WIDTH'(cand_reg) : sum_reg;
    assign sum_over  = sum_add > {1'b0, n_reg};
    assign last_cand = (cand_reg == half_reg);
    assign out_free  = !mvalid_reg || m_tready;

    abn_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (rem_ctrl),
        .dividend (n_reg),
        .divisor  (cand_reg),
        .stat     (rem_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            abn_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = s_trivial ? abn_pkg::ST_DONE : abn_pkg::ST_LOAD;
                end
            end
            abn_pkg::ST_LOAD: begin
                state_next = abn_pkg::ST_DIV;
            end
            abn_pkg::ST_DIV: begin
                if (rem_stat.done) begin
                    state_next = (sum_over || last_cand) ? abn_pkg::ST_DONE
                                                         : abn_pkg::ST_LOAD;
                end
            end
            abn_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = abn_pkg::ST_IDLE;
                end
            end
            default: state_next = abn_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        s_tready       = 1'b0;
        rem_ctrl.start = 1'b0;
        unique case (state_reg)
            abn_pkg::ST_IDLE: s_tready       = 1'b1;
            abn_pkg::ST_LOAD: rem_ctrl.start = 1'b1;
            abn_pkg::ST_DIV,
            abn_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        n_next      = n_reg;
        half_next   = half_reg;
        cand_next   = cand_reg;
        sum_next    = sum_reg;
        flag_next   = flag_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mflag_next  = mflag_reg;
        unique case (state_reg)
            abn_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    n_next    = s_number;
                    half_next = s_number[abn_pkg::VALUE_WIDTH-1:1];
                    cand_next = abn_pkg::CAND_WIDTH'(1);
                    sum_next  = '0;
                    flag_next = 1'b0;
                end
            end
            abn_pkg::ST_LOAD: ;
            abn_pkg::ST_DIV: begin
                if (rem_stat.done) begin
                    sum_next  = sum_add;
                    flag_next = sum_over;
                    cand_next = cand_reg + 1'b1;
                end
            end
            abn_pkg::ST_DONE: begin
                if (out_free) begin
                    mvalid_next = 1'b1;
                    mflag_next  = flag_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= abn_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            cand_reg   <= '0;
            sum_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            cand_reg   <= cand_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        half_reg  <= half_next;
        flag_reg  <= flag_next;
        mflag_reg <= mflag_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {{(abn_pkg::TDATA_OUT_W-1){1'b0}}, mflag_reg};

`ifndef SYNTHESIS
    a_trivial_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_trivial) |=> (state_reg == abn_pkg::ST_DONE))
        else $error("trivial value did not go straight to done");

    a_cand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == abn_pkg::ST_DIV) |-> (cand_reg != '0 && cand_reg <= half_reg))
        else $error("candidate divisor out of range");

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == abn_pkg::ST_DIV) |-> (sum_reg <= {1'b0, n_reg}))
        else $error("divisor sum passed the value without stopping");

    a_idle_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rem_stat.busy)
        else $error("remainder unit busy while idle");
`endif

endmodule

`default_nettype wire

@@ verif/abundant_number_check_test.sv @@
// Testbench for abundant_number_check: directed values, stalls and random streams.
`timescale 1ns / 1ps

module abundant_number_check_test;

    localparam int WATCHDOG_LIMIT  = 1_200_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 50;
    localparam int REPORT_LIMIT    = 10;

    typedef logic signed [abn_pkg::VALUE_WIDTH-1:0] number_t;

    typedef struct {
        number_t number;
        bit      abundant;
    } verdict_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [abn_pkg::TDATA_IN_W-1:0]   s_tdata  = '0;     // [15:0] number
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [abn_pkg::TDATA_OUT_W-1:0]  m_tdata;           // [0] abundant, [7:1] zero

    verdict_t pending_verdicts[$];
    int       error_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    int       stall_requests = 0;
    int       stall_served   = 0;
    int       hold_left      = 0;
    int       quiet_cycles   = 0;

    abundant_number_check DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Sum every proper divisor up to half the value; non-positive values are never abundant.
    function automatic bit abundance_of(number_t number);
        int value;
        int divisor_total;
        int cand;
        value = number;
        divisor_total = 0;
        if (value <= 0) begin
            return 1'b0;
        end
        for (cand = 1; cand <= value / 2; cand++) begin
            if (value % cand == 0) begin
                divisor_total += cand;
            end
        end
        return divisor_total > value;
    endfunction

    // Mostly small positives keep the serial search short; negatives cover the upper bits.
    function automatic number_t random_number();
        int      pick;
        number_t value;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            value = number_t'($urandom);
            value[abn_pkg::VALUE_WIDTH-1] = 1'b1;
        end else if (pick < 36) begin
            value = number_t'($urandom_range(0, 1));
        end else if (pick < 97) begin
            value = number_t'($urandom_range(2, 511));
        end else begin
            value = number_t'($urandom_range(512, 4095));
        end
        return value;
    endfunction

    task automatic note_mismatch(string what);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    task automatic send_number(number_t value);
        logic [abn_pkg::TDATA_IN_W-1:0] word;
        word = '0;
        word[abn_pkg::VALUE_WIDTH-1:0] = value;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(verdict_t'{value, abundance_of(value)});
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_directed();
        number_t values [16];
        values = '{16'sd0, 16'sd1, 16'sd2, -16'sd1, -16'sd32768, 16'sd32767,
                   16'sd6, 16'sd12, 16'sd18, 16'sd20, 16'sd28, 16'sd496,
                   16'sd945, 16'sd11, 16'sd24, 16'sd32760};
        foreach (values[i]) begin
            send_number(values[i]);
        end
        stop_sending();
        wait_drained();
    endtask

    // Hold the result side off while the sender keeps offering quick items.
    task automatic test_backpressure();
        number_t value;
        stall_requests <= stall_requests + 1;
        repeat (8) begin
            value = number_t'($urandom);
            value[abn_pkg::VALUE_WIDTH-1] = 1'b1;
            send_number(value);
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (3) send_number(number_t'($urandom_range(1, 200)));
        stop_sending();
        wait_drained();
        repeat (3) send_number(number_t'($urandom_range(1, 200)));
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random(int count, int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
        repeat (count) send_number(random_number());
        stop_sending();
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_served != stall_requests) begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_OFF_CYCLES - 1;
            stall_served <= stall_requests;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, abundant=%0b", m_tdata[0]));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.abundant) begin
                    note_mismatch($sformatf("number %0d: abundant expected %0b, got %0b",
                                            want.number, want.abundant, m_tdata[0]));
                end
            end
        end
    end

    // Reset the count on every transfer; a long silence means the block has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("abundant_number_check: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(24, 25, 87);
        test_random(23, 87, 25);
        test_random(23, 0, 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("abundant_number_check: match");
        end else begin
            $display("abundant_number_check: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/abn_pkg.sv
sv/abn_rem.sv
sv/abundant_number_check.sv
verif/abundant_number_check_test.sv
